// File: rtl/tbp_pkg.sv
package tbp_pkg;

	// Counter reset values
	localparam logic [1:0] CTR_STRONG_TAKEN  = 2'b11;
	localparam logic [1:0] CTR_STRONG_GSHARE = 2'b00;

	// One resolved branch
	typedef struct packed {
		logic [31:0] pc;
		logic        taken;
	} tbp_in_t;

	// One prediction report
	typedef struct packed {
		logic        predicted_taken;
		logic        prediction_correct;
		logic [31:0] correct_total;
	} tbp_out_t;

	// Control sequence: clearing pass, wait for a branch, read-modify-write
	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_CALC  = 3'b100
	} tbp_state_t;

	// 2-bit saturating counter step
	function automatic logic [1:0] sat_train(input logic [1:0] ctr, input logic up);
		logic [1:0] nxt;
		nxt = ctr;
		if (up) begin
			if (ctr != 2'b11) nxt = ctr + 2'd1;
		end else begin
			if (ctr != 2'b00) nxt = ctr - 2'd1;
		end
		return nxt;
	endfunction

endpackage

// File: rtl/tbp_ram.sv
module tbp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	// One registered read port; data holds until the next read
	always_ff @(posedge clk) begin
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/tournament_branch_predictor.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_data  (tbp_in_t: pc, taken)
// out     | output    | out_valid / out_ready | out_data (tbp_out_t)
//
// For each branch the tables are read on acceptance and the counters are
// written back in the write-back state, a read-modify-write through the
// single registered read port of each table RAM.
// After reset a clearing pass over all 2**INDEX_BITS entries loads the counters with
// their reset values; in_ready stays low during it.
// A finished result waits in the output register; a new branch is taken while it
// waits, and the write-back stalls only if the register is still full then.
module tournament_branch_predictor
	import tbp_pkg::*;
#(
	parameter int INDEX_BITS   = 11,
	parameter int HISTORY_BITS = 11
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  tbp_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output tbp_out_t out_data
);

	localparam int DEPTH = 1 << INDEX_BITS;
	localparam int XW    = (INDEX_BITS > HISTORY_BITS) ? INDEX_BITS : HISTORY_BITS;

	tbp_state_t              state_q;
	logic [INDEX_BITS-1:0]   clr_q;
	logic [HISTORY_BITS-1:0] hist_q;
	logic [31:0]             hit_q;
	logic                    out_valid_q;
	tbp_out_t                out_q;

	logic [INDEX_BITS-1:0]   bidx_s1;
	logic [INDEX_BITS-1:0]   gidx_s1;
	logic                    taken_s1;

	logic                    accept;
	logic                    calc_done;
	logic [XW-1:0]           hist_ext;
	logic [INDEX_BITS-1:0]   rd_bidx;
	logic [INDEX_BITS-1:0]   rd_gidx;

	logic                    we;
	logic [INDEX_BITS-1:0]   bc_waddr;
	logic [INDEX_BITS-1:0]   g_waddr;
	logic [3:0]              bc_wdata;
	logic [1:0]              g_wdata;
	logic [3:0]              bc_rdata;
	logic [1:0]              g_rdata;

	logic                    bpred;
	logic                    gpred;
	logic                    pred;
	logic                    ok;
	logic                    bok;
	logic                    gok;
	logic [1:0]              cho_new;
	logic [31:0]             hit_new;

	// Input handshake and read addresses
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign hist_ext = XW'(hist_q);
	assign rd_bidx  = in_data.pc[INDEX_BITS-1:0];
	assign rd_gidx  = rd_bidx ^ hist_ext[INDEX_BITS-1:0];

	// Write-back completes when the output register is free
	assign calc_done = (state_q == S_CALC) && (!out_valid_q || out_ready);

	// Prediction and training from the read data
	always_comb begin
		bpred = bc_rdata[3];
		gpred = g_rdata[1];
		pred  = bc_rdata[1] ? bpred : gpred;
		ok    = (pred == taken_s1);
		bok   = (bpred == taken_s1);
		gok   = (gpred == taken_s1);
		priority if (bok && !gok) cho_new = sat_train(bc_rdata[1:0], 1'b1);
		else if (gok && !bok) cho_new = sat_train(bc_rdata[1:0], 1'b0);
		else cho_new = bc_rdata[1:0];
		hit_new = (ok && (hit_q != '1)) ? hit_q + 32'd1 : hit_q;
	end

	// Table writes: clearing pass or counter write-back
	always_comb begin
		if (state_q == S_CLEAR) begin
			we       = 1'b1;
			bc_waddr = clr_q;
			g_waddr  = clr_q;
			bc_wdata = {CTR_STRONG_TAKEN, CTR_STRONG_GSHARE};
			g_wdata  = CTR_STRONG_TAKEN;
		end else begin
			we       = calc_done;
			bc_waddr = bidx_s1;
			g_waddr  = gidx_s1;
			bc_wdata = {sat_train(bc_rdata[3:2], taken_s1), cho_new};
			g_wdata  = sat_train(g_rdata, taken_s1);
		end
	end

	// Bimodal counter in [3:2], chooser counter in [1:0]
	tbp_ram #(
		.WIDTH(4),
		.DEPTH(DEPTH)
	) u_bc_ram (
		.clk  (clk),
		.we   (we),
		.waddr(bc_waddr),
		.wdata(bc_wdata),
		.re   (accept),
		.raddr(rd_bidx),
		.rdata(bc_rdata)
	);

	// Gshare counters
	tbp_ram #(
		.WIDTH(2),
		.DEPTH(DEPTH)
	) u_g_ram (
		.clk  (clk),
		.we   (we),
		.waddr(g_waddr),
		.wdata(g_wdata),
		.re   (accept),
		.raddr(rd_gidx),
		.rdata(g_rdata)
	);

	// Control sequence, history, hit count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			hist_q      <= '0;
			hit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + INDEX_BITS'(1);
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) state_q <= S_CALC;
				end
				S_CALC: begin
					if (calc_done) begin
						state_q <= S_IDLE;
						// newest outcome enters at bit 0, oldest drops off the top
						hist_q  <= HISTORY_BITS'({hist_q, taken_s1});
						hit_q   <= hit_new;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
			if (calc_done) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Branch fields held for the write-back
	always_ff @(posedge clk) begin
		if (accept) begin
			bidx_s1  <= rd_bidx;
			gidx_s1  <= rd_gidx;
			taken_s1 <= in_data.taken;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (calc_done) begin
			out_q.predicted_taken    <= pred;
			out_q.prediction_correct <= ok;
			out_q.correct_total      <= hit_new;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	// An accepted branch always goes to the write-back state
	a_accept_calc: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_CALC))
		else $error("accepted branch did not reach write-back");

	// A result appears only after a write-back
	a_out_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_CALC))
		else $error("result without write-back");

	// The tables are never written while waiting for a branch
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !we)
		else $error("table write while idle");

	// The hit count never goes down
	a_hit_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |=> (hit_q >= $past(hit_q)))
		else $error("hit count decreased");
`endif

endmodule
